// File: src/bia_pkg.sv
// Shared constants for the bitmap identifier allocator.
`default_nettype none

package bia_pkg;

    // Default number of identifiers managed by the bitmap.
    localparam int CAPACITY_DEF = 4096;

    // Fixed widths of the transfer fields.
    localparam int IDX_W = 12;
    localparam int CNT_W = 13;

    // Request codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Response status codes.
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // Bitmap byte patterns.
    localparam logic [7:0] BYTE_FULL = 8'hFF;
    localparam logic [7:0] BIT_MSB   = 8'h80;

endpackage : bia_pkg

`default_nettype wire

// File: src/bitmap_id_allocator.sv
// Bitmap identifier allocator: first-fit allocate and free over a byte-wide RAM.
//
// Request channel (req_valid/req_ready): opcode selects allocate or free;
// release_index names the identifier to free. Response channel
// (rsp_valid/rsp_ready): one response per request with granted_index, status
// and the remaining free count.
// Free and hinted allocate do one RAM read, then the modify and write-back
// that registers the response. An allocate without a hint scans bytes from
// a low-water pointer (every byte below it is known full), one RAM read per
// cycle, reading at most CAPACITY/8 bytes. A freed byte pulls the pointer
// back down.
// One request is in flight at a time; req_ready is high while idle.
// A response waits in the output register while rsp_ready is low; the next
// request is still taken, and its write-back waits for the register to free.
// After reset the bitmap RAM is cleared one byte per cycle, all CAPACITY/8
// bytes (512 at the default), with req_ready low. Free count resets to
// CAPACITY and no hint is held.
`default_nettype none

module bitmap_id_allocator
    import bia_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire logic             opcode,
    input  wire logic [IDX_W-1:0] release_index,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output logic      [IDX_W-1:0] granted_index,
    output logic                  status,
    output logic      [CNT_W-1:0] remaining
);

    localparam int MAP_BYTES = CAPACITY / 8;
    localparam int BAW       = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int PW        = $clog2(MAP_BYTES + 1);
    localparam int FCW       = $clog2(CAPACITY + 1);

    localparam logic [BAW-1:0] LAST_BYTE = BAW'(MAP_BYTES - 1);
    localparam logic [PW-1:0]  PTR_FULL  = PW'(MAP_BYTES);
    localparam logic [FCW-1:0] CNT_MAX   = FCW'(CAPACITY);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_RMW   = 2'd2;

    localparam logic [2:0] M_FREE   = 3'd0;
    localparam logic [2:0] M_HINT   = 3'd1;
    localparam logic [2:0] M_SCAN   = 3'd2;
    localparam logic [2:0] M_FULL   = 3'd3;
    localparam logic [2:0] M_IGNORE = 3'd4;

    logic [1:0]       state_reg, state_next;
    logic [2:0]       mode_reg, mode_next;
    logic [BAW-1:0]   addr_reg, addr_next;
    logic [2:0]       bit_reg, bit_next;
    logic [IDX_W-1:0] rel_reg, rel_next;
    logic [PW-1:0]    ptr_reg, ptr_next;
    logic             hint_valid_reg, hint_valid_next;
    logic [BAW-1:0]   hint_byte_reg, hint_byte_next;
    logic [2:0]       hint_bit_reg, hint_bit_next;
    logic [FCW-1:0]   free_cnt_reg, free_cnt_next;
    logic [BAW-1:0]   clr_reg, clr_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [IDX_W-1:0] granted_reg, granted_next;
    logic             status_reg, status_next;
    logic [CNT_W-1:0] remaining_reg, remaining_next;

    logic             ram_wr_en;
    logic [BAW-1:0]   ram_wr_addr;
    logic [7:0]       ram_wr_data;
    logic             ram_rd_en;
    logic [BAW-1:0]   ram_rd_addr;
    logic [7:0]       ram_rd_data;

    logic             rsp_free;
    logic             rel_in_range;
    logic [BAW-1:0]   rel_byte;
    logic [2:0]       first_zero;
    logic [FCW-1:0]   cnt_inc;
    logic [FCW-1:0]   cnt_dec;

    // Bit position (MSB first) of the first clear bit in a byte.
    function automatic logic [2:0] find_first_zero(input logic [7:0] data);
        logic [2:0] pos;
        pos = 3'd0;
        for (int j = 0; j < 8; j++)
        begin
            if (!data[j])
            begin
                pos = 3'(7 - j);
            end
        end
        return pos;
    endfunction

    bia_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign req_ready     = (state_reg == S_IDLE);
    assign rsp_valid     = rsp_valid_reg;
    assign granted_index = granted_reg;
    assign status        = status_reg;
    assign remaining     = remaining_reg;

    assign rsp_free     = !rsp_valid_reg || rsp_ready;
    assign rel_in_range = (32'(release_index) < 32'(MAP_BYTES * 8));
    assign rel_byte     = BAW'(release_index >> 3);
    assign first_zero   = find_first_zero(ram_rd_data);
    assign cnt_inc      = (free_cnt_reg < CNT_MAX) ? free_cnt_reg + FCW'(1) : free_cnt_reg;
    assign cnt_dec      = (free_cnt_reg != '0) ? free_cnt_reg - FCW'(1) : free_cnt_reg;

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        addr_next       = addr_reg;
        bit_next        = bit_reg;
        rel_next        = rel_reg;
        ptr_next        = ptr_reg;
        hint_valid_next = hint_valid_reg;
        hint_byte_next  = hint_byte_reg;
        hint_bit_next   = hint_bit_reg;
        free_cnt_next   = free_cnt_reg;
        clr_next        = clr_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        granted_next    = granted_reg;
        status_next     = status_reg;
        remaining_next  = remaining_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = addr_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = addr_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                ram_wr_data = '0;
                clr_next    = clr_reg + BAW'(1);
                if (clr_reg == LAST_BYTE)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    rel_next   = release_index;
                    state_next = S_RMW;
                    if (opcode == OP_FREE)
                    begin
                        mode_next = rel_in_range ? M_FREE : M_IGNORE;
                        addr_next = rel_byte;
                        bit_next  = release_index[2:0];
                    end
                    else if (hint_valid_reg)
                    begin
                        mode_next = M_HINT;
                        addr_next = hint_byte_reg;
                        bit_next  = hint_bit_reg;
                    end
                    else if (ptr_reg == PTR_FULL)
                    begin
                        mode_next = M_FULL;
                    end
                    else
                    begin
                        mode_next = M_SCAN;
                        addr_next = ptr_reg[BAW-1:0];
                    end
                    ram_rd_en   = (mode_next == M_FREE) || (mode_next == M_HINT)
                                  || (mode_next == M_SCAN);
                    ram_rd_addr = addr_next;
                end
            end

            S_RMW:
            begin
                unique case (mode_reg)
                    M_FREE:
                    begin
                        if (rsp_free)
                        begin
                            ram_wr_en       = 1'b1;
                            ram_wr_data     = ram_rd_data & ~(BIT_MSB >> bit_reg);
                            hint_valid_next = 1'b1;
                            hint_byte_next  = addr_reg;
                            hint_bit_next   = bit_reg;
                            free_cnt_next   = cnt_inc;
                            if (PW'(addr_reg) < ptr_reg)
                            begin
                                ptr_next = PW'(addr_reg);
                            end
                            rsp_valid_next = 1'b1;
                            granted_next   = rel_reg;
                            status_next    = ST_OK;
                            remaining_next = CNT_W'(cnt_inc);
                            state_next     = S_IDLE;
                        end
                    end

                    M_HINT:
                    begin
                        if (rsp_free)
                        begin
                            ram_wr_en       = 1'b1;
                            ram_wr_data     = ram_rd_data | (BIT_MSB >> bit_reg);
                            hint_valid_next = 1'b0;
                            free_cnt_next   = cnt_dec;
                            rsp_valid_next  = 1'b1;
                            granted_next    = IDX_W'({addr_reg, bit_reg});
                            status_next     = ST_OK;
                            remaining_next  = CNT_W'(cnt_dec);
                            state_next      = S_IDLE;
                        end
                    end

                    M_SCAN:
                    begin
                        if (ram_rd_data == BYTE_FULL)
                        begin
                            if (addr_reg == LAST_BYTE)
                            begin
                                // whole map is full
                                if (rsp_free)
                                begin
                                    ptr_next       = PTR_FULL;
                                    rsp_valid_next = 1'b1;
                                    granted_next   = '0;
                                    status_next    = ST_FULL;
                                    remaining_next = CNT_W'(free_cnt_reg);
                                    state_next     = S_IDLE;
                                end
                            end
                            else
                            begin
                                addr_next   = addr_reg + BAW'(1);
                                ptr_next    = PW'(addr_reg) + PW'(1);
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = addr_reg + BAW'(1);
                            end
                        end
                        else if (rsp_free)
                        begin
                            ram_wr_en       = 1'b1;
                            ram_wr_data     = ram_rd_data | (BIT_MSB >> first_zero);
                            hint_valid_next = 1'b0;
                            free_cnt_next   = cnt_dec;
                            ptr_next        = PW'(addr_reg);
                            rsp_valid_next  = 1'b1;
                            granted_next    = IDX_W'({addr_reg, first_zero});
                            status_next     = ST_OK;
                            remaining_next  = CNT_W'(cnt_dec);
                            state_next      = S_IDLE;
                        end
                    end

                    M_FULL:
                    begin
                        if (rsp_free)
                        begin
                            rsp_valid_next = 1'b1;
                            granted_next   = '0;
                            status_next    = ST_FULL;
                            remaining_next = CNT_W'(free_cnt_reg);
                            state_next     = S_IDLE;
                        end
                    end

                    M_IGNORE:
                    begin
                        if (rsp_free)
                        begin
                            rsp_valid_next = 1'b1;
                            granted_next   = rel_reg;
                            status_next    = ST_OK;
                            remaining_next = CNT_W'(free_cnt_reg);
                            state_next     = S_IDLE;
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            ptr_reg        <= '0;
            hint_valid_reg <= 1'b0;
            hint_byte_reg  <= '0;
            hint_bit_reg   <= '0;
            free_cnt_reg   <= CNT_MAX;
            clr_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            hint_valid_reg <= hint_valid_next;
            hint_byte_reg  <= hint_byte_next;
            hint_bit_reg   <= hint_bit_next;
            free_cnt_reg   <= free_cnt_next;
            clr_reg        <= clr_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        addr_reg      <= addr_next;
        bit_reg       <= bit_next;
        rel_reg       <= rel_next;
        granted_reg   <= granted_next;
        status_reg    <= status_next;
        remaining_reg <= remaining_next;
    end

endmodule : bitmap_id_allocator

`default_nettype wire

// File: src/bia_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module bia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds until the next read
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : bia_ram

`default_nettype wire
